// ===== src/des_pkg.sv =====
// des_pkg: shared constants, tables and bit-level functions for the des block cipher
// no dependencies
package des_pkg;

    localparam int MaxRounds = 16;
    localparam int BlockW    = 64;
    localparam int HalfW     = 32;
    localparam int KeyW      = 48;
    localparam int CdW       = 28;

    typedef logic [BlockW-1:0] block_t;
    typedef logic [HalfW-1:0]  half_t;
    typedef logic [KeyW-1:0]   subkey_t;
    typedef logic [CdW-1:0]    cd_half_t;

    // payload carried by each cell of the round chain
    typedef struct packed {
        logic     enc;
        half_t    l;
        half_t    r;
        cd_half_t c;
        cd_half_t d;
    } des_cell_t;

    // position tables, entry 1 is the msb of the source word
    localparam logic [7:0] TabIp [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam logic [7:0] TabFp [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam logic [7:0] TabE [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam logic [7:0] TabP [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam logic [7:0] TabPc1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,19,11,3,60,52,44,36,
        63,55,47,39,31,23,15,7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,21,13,5,28,20,12,4 };

    localparam logic [7:0] TabPc2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,
        23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,
        44,49,39,56,34,53,46,42,50,36,29,32 };

    localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] TabSbox [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic block_t perm_ip(input block_t w);
        block_t o;
        for (int i = 0; i < 64; i++) o[63-i] = w[64 - int'(TabIp[i])];
        return o;
    endfunction

    function automatic block_t perm_fp(input block_t w);
        block_t o;
        for (int i = 0; i < 64; i++) o[63-i] = w[64 - int'(TabFp[i])];
        return o;
    endfunction

    function automatic logic [55:0] perm_pc1(input block_t w);
        logic [55:0] o;
        for (int i = 0; i < 56; i++) o[55-i] = w[64 - int'(TabPc1[i])];
        return o;
    endfunction

    function automatic subkey_t perm_pc2(input logic [55:0] w);
        subkey_t o;
        for (int i = 0; i < 48; i++) o[47-i] = w[56 - int'(TabPc2[i])];
        return o;
    endfunction

    function automatic cd_half_t rotl(input cd_half_t v, input logic [1:0] s);
        return (s == 2'd2) ? {v[CdW-3:0], v[CdW-1:CdW-2]} : {v[CdW-2:0], v[CdW-1]};
    endfunction

    function automatic cd_half_t rotr(input cd_half_t v, input logic [1:0] s);
        return (s == 2'd2) ? {v[1:0], v[CdW-1:2]} : {v[0], v[CdW-1:1]};
    endfunction

    // feistel function: expansion, key mix, s-boxes, p permutation
    function automatic half_t feistel(input half_t r, input subkey_t k);
        subkey_t x;
        half_t   s;
        half_t   o;
        logic [5:0] six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
        x = x ^ k;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = TabSbox[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) o[31-i] = s[32 - int'(TabP[i])];
        return o;
    endfunction

endpackage

// ===== src/des_stream_if.sv =====
// des_stream_if: valid/ready channel carrying a generic payload
// no dependencies
interface des_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/des_round_cell.sv =====
// des_round_cell: one des round with its key-schedule step, registered
// depends on des_pkg
module des_round_cell #(
    parameter int IDX    = 0,
    parameter int ROUNDS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vin,
    input  des_pkg::des_cell_t  din,
    output logic                vout,
    output des_pkg::des_cell_t  dout
);
    import des_pkg::*;

    localparam logic [1:0] EncRot = TabRot[IDX];
    // decryption starts from the last key and walks back
    localparam logic [1:0] DecRot = TabRot[ROUNDS - 1 - IDX];
    localparam bit DecFirst = (IDX == 0);

    des_cell_t cell_next;
    des_cell_t cell_reg;
    logic      v_reg;
    cd_half_t  c_k;
    cd_half_t  d_k;
    cd_half_t  c_after;
    cd_half_t  d_after;

    always_comb
    begin
        if (din.enc)
        begin
            c_k = rotl(din.c, EncRot);
            d_k = rotl(din.d, EncRot);
            c_after = c_k;
            d_after = d_k;
        end
        else
        begin
            c_k = din.c;
            d_k = din.d;
            if (DecFirst && ROUNDS == 1)
            begin
                c_after = din.c;
                d_after = din.d;
            end
            else
            begin
                c_after = (IDX == ROUNDS - 1) ? din.c : rotr(din.c, DecRot);
                d_after = (IDX == ROUNDS - 1) ? din.d : rotr(din.d, DecRot);
            end
        end
        cell_next.enc = din.enc;
        cell_next.l   = din.r;
        cell_next.r   = din.l ^ feistel(din.r, perm_pc2({c_k, d_k}));
        cell_next.c   = c_after;
        cell_next.d   = d_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign vout = v_reg;
    assign dout = cell_reg;
endmodule

// ===== src/des_block_cipher.sv =====
// des_block_cipher: pipelined des engine, one round cell per round
// depends on des_pkg, des_stream_if, des_round_cell
//
// One transaction in, one transaction out. Every round is its own cell, so the block
// accepts a new block every cycle while the output is taken, and each result passes
// through the ROUNDS round cells and then the output register. The chain stalls as a
// whole when the output is not taken; a key may change with every block.
module des_block_cipher #(
    parameter int ROUNDS = des_pkg::MaxRounds
) (
    input  logic          clk,
    input  logic          rst_n,
    des_stream_if.sink    in_ch,
    des_stream_if.source  out_ch
);
    import des_pkg::*;

    // in_ch.data = {command, data_block, cipher_key}
    logic       command;
    block_t     data_block;
    block_t     cipher_key;
    logic       en;
    logic [55:0] cd0;
    block_t     ipw;
    des_cell_t  c0;
    // total rotation of a full schedule is 28, so the decrypt start key is
    // the pc1 output rotated left by the partial sum
    cd_half_t   cs;
    cd_half_t   ds;

    logic      v_chain [ROUNDS+1];
    des_cell_t d_chain [ROUNDS+1];

    logic   out_v_reg;
    block_t result_reg;

    function automatic cd_half_t rot_total(input cd_half_t v);
        cd_half_t t;
        t = v;
        for (int i = 0; i < ROUNDS; i++) t = rotl(t, TabRot[i]);
        return t;
    endfunction

    assign command    = in_ch.data[128];
    assign data_block = in_ch.data[127:64];
    assign cipher_key = in_ch.data[63:0];

    assign en          = !out_v_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_comb
    begin
        cd0 = perm_pc1(cipher_key);
        ipw = perm_ip(data_block);
        cs  = rot_total(cd0[55:28]);
        ds  = rot_total(cd0[27:0]);
        c0.enc = command;
        c0.l   = ipw[63:32];
        c0.r   = ipw[31:0];
        c0.c   = command ? cd0[55:28] : cs;
        c0.d   = command ? cd0[27:0]  : ds;
    end

    assign v_chain[0] = in_ch.valid;
    assign d_chain[0] = c0;

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        des_round_cell #(.IDX(g), .ROUNDS(ROUNDS)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (v_chain[g]),
            .din  (d_chain[g]),
            .vout (v_chain[g+1]),
            .dout (d_chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v_chain[ROUNDS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= perm_fp({d_chain[ROUNDS].r, d_chain[ROUNDS].l});
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.data  = result_reg;
endmodule

// ===== verif/tb_des_block_cipher.sv =====
// tb_des_block_cipher: self-checking testbench for the pipelined des engine
// depends on des_pkg, des_stream_if and des_block_cipher
module tb_des_block_cipher;
    import des_pkg::*;

    localparam int NumRandom  = 1200;
    localparam int IdleLimit  = 4000;
    localparam int LongHold   = 300;
    localparam int DrainWait  = 40;
    localparam logic CmdEncrypt = 1'b1;
    localparam logic CmdDecrypt = 1'b0;

    logic clk;
    logic rst_n;

    des_stream_if #(.W(1 + 2 * BlockW)) in_ch ();
    des_stream_if #(.W(BlockW))         out_ch ();

    des_block_cipher #(.ROUNDS(MaxRounds)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    typedef struct {
        logic   cmd;
        block_t blk;
        block_t key;
        logic   known;
        block_t result;
    } cipher_row_t;

    block_t cipher_q[$];
    int     errors;
    int     n_sent;
    int     n_checked;
    int     n_enc;
    int     n_dec;
    int     idle_cycles;
    logic   hold_req;
    logic   stim_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report(input string what, input block_t got, input block_t want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // bit-level des computation, tables taken from the package
    function automatic block_t des_compute(input logic cmd, input block_t blk, input block_t key);
        subkey_t    sk [MaxRounds];
        logic [55:0] cd;
        logic [55:0] cdr;
        cd_half_t   c;
        cd_half_t   d;
        block_t     pb;
        block_t     res;
        half_t      l;
        half_t      r;
        half_t      t;
        half_t      sbo;
        half_t      f;
        subkey_t    x;
        subkey_t    k;
        logic [5:0] six;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(TabPc1[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int rd = 0; rd < MaxRounds; rd++)
        begin
            for (int s = 0; s < int'(TabRot[rd]); s++)
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cdr = {c, d};
            for (int i = 0; i < 48; i++) sk[rd][47-i] = cdr[56 - int'(TabPc2[i])];
        end
        for (int i = 0; i < 64; i++) pb[63-i] = blk[64 - int'(TabIp[i])];
        l = pb[63:32];
        r = pb[31:0];
        for (int rd = 0; rd < MaxRounds; rd++)
        begin
            k = (cmd == CmdEncrypt) ? sk[rd] : sk[MaxRounds-1-rd];
            for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
            x = x ^ k;
            for (int b = 0; b < 8; b++)
            begin
                six = x[47-6*b -: 6];
                sbo[31-4*b -: 4] = TabSbox[b][{six[5], six[0]} * 16 + six[4:1]];
            end
            for (int i = 0; i < 32; i++) f[31-i] = sbo[32 - int'(TabP[i])];
            t = l ^ f;
            l = r;
            r = t;
        end
        pb = {r, l};
        for (int i = 0; i < 64; i++) res[63-i] = pb[64 - int'(TabFp[i])];
        return res;
    endfunction

    task automatic send_block(input cipher_row_t row, input int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {row.cmd, row.blk, row.key};
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        cipher_q.push_back(row.known ? row.result : des_compute(row.cmd, row.blk, row.key));
        n_sent++;
        if (row.cmd == CmdEncrypt) n_enc++; else n_dec++;
    endtask

    // directed vectors, published results typed in where well known
    cipher_row_t directed [15] = '{
        '{CmdEncrypt, 64'h0123456789ABCDEF, 64'h133457799BBCDFF1, 1'b1, 64'h85E813540F0AB405},
        '{CmdDecrypt, 64'h85E813540F0AB405, 64'h133457799BBCDFF1, 1'b1, 64'h0123456789ABCDEF},
        '{CmdEncrypt, 64'h0000000000000000, 64'h0000000000000000, 1'b1, 64'h8CA64DE9C1B123A7},
        '{CmdDecrypt, 64'h8CA64DE9C1B123A7, 64'h0000000000000000, 1'b1, 64'h0000000000000000},
        '{CmdEncrypt, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
        '{CmdDecrypt, 64'h7359B2163E4EDC58, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'hFFFFFFFFFFFFFFFF},
        '{CmdEncrypt, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 1'b0, 64'h0},
        '{CmdDecrypt, 64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
        // parity bits flipped must not change the result
        '{CmdEncrypt, 64'h0123456789ABCDEF, 64'h123456789ABCDEF0, 1'b1, 64'h85E813540F0AB405},
        // weak keys, then two keys with a single bit set
        '{CmdEncrypt, 64'h0123456789ABCDEF, 64'h0101010101010101, 1'b0, 64'h0},
        '{CmdDecrypt, 64'h0123456789ABCDEF, 64'hFEFEFEFEFEFEFEFE, 1'b0, 64'h0},
        '{CmdEncrypt, 64'hAAAAAAAAAAAAAAAA, 64'h1F1F1F1F0E0E0E0E, 1'b0, 64'h0},
        '{CmdDecrypt, 64'h5555555555555555, 64'hE0E0E0E0F1F1F1F1, 1'b0, 64'h0},
        '{CmdEncrypt, 64'h8000000000000001, 64'h8000000000000000, 1'b0, 64'h0},
        '{CmdDecrypt, 64'h0000000000000001, 64'h0000000000000002, 1'b0, 64'h0}
    };

    // stimulus
    initial
    begin
        cipher_row_t row;
        int          pick;
        errors      = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_enc       = 0;
        n_dec       = 0;
        hold_req    = 1'b0;
        stim_done   = 1'b0;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send_block(directed[i], $urandom_range(0, 3));
        for (int n = 0; n < NumRandom; n++)
        begin
            if (n == NumRandom / 3) hold_req <= 1'b1;
            if (n == 2 * NumRandom / 3)
            begin
                // let the pipe drain completely before continuing
                in_ch.valid <= 1'b0;
                while (cipher_q.size() != 0) @(posedge clk);
            end
            pick     = $urandom_range(0, 9);
            row.cmd  = 1'($urandom_range(0, 1));
            row.blk  = {$urandom, $urandom};
            row.key  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            row.known = 1'b0;
            row.result = '0;
            // back-to-back bursts without gaps part of the time
            send_block(row, (n % 200 < 40) ? 0 : $urandom_range(0, 3));
        end
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // result side ready with random stalls and one long hold
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                hold_req <= 1'b0;
            end
            else
            begin
                int stall;
                stall = $urandom_range(0, 3);
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                if (cipher_q.size() == 0)
                    report("unexpected transaction", out_ch.data, '0);
                else
                begin
                    block_t want;
                    want = cipher_q.pop_front();
                    if (out_ch.data !== want) report("result_block", out_ch.data, want);
                    n_checked++;
                end
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("tb_des_block_cipher: FAIL");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // end of run
    initial
    begin
        wait (stim_done === 1'b1);
        while (cipher_q.size() != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (cipher_q.size() != 0) errors++;
        $display("covered %0d blocks (%0d encrypt, %0d decrypt), %0d results checked",
                 n_sent, n_enc, n_dec, n_checked);
        $display("known vectors, weak and all-zero/all-one keys, long output stall, drain");
        if (errors == 0)
            $display("tb_des_block_cipher: PASS");
        else
            $display("tb_des_block_cipher: FAIL");
        $finish;
    end

endmodule
